/* rtl/rfc_pkg.sv */
// Shared types and constants of the response frame checker.
package rfc_pkg;

  // Frame layout constants
  localparam logic [7:0] FrameHeader  = 8'hAA;
  localparam int unsigned CountW      = 9;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW:0] MinFrameSize = (CountW+1)'(5);

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  // Stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXPECTED_ID  = 1'b0,
    REG_EXPECTED_CMD = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_HEADER   = 3'd2,
    ST_ID       = 3'd3,
    ST_COMMAND  = 3'd4,
    ST_SIZE     = 3'd5,
    ST_CHECKSUM = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FE_NONE    = 2'd0,
    FE_HEADER  = 2'd1,
    FE_ID      = 2'd2,
    FE_COMMAND = 2'd3
  } field_err_e;

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    result_kind_e kind;
    logic [7:0]   payload_byte;
    logic [7:0]   payload_index;
    status_e      frame_status;
    logic [7:0]   declared_length;
  } result_t;

endpackage

/* rtl/response_frame_checker_core.sv */
// Top level of the response frame checker.
// Checks a servo response frame (0xAA, id, command, length L, L payload bytes,
// inverted-sum checksum) one byte per item. Every payload byte comes out as an
// item with its index; the byte marked tlast gives one status item (short,
// header, id, command, size, checksum, in that priority, else ok). The block
// takes one byte per cycle while the receiver takes results: an input register
// feeds the checking logic, whose result goes into an output register. Every
// byte leaves the input register once the output register is free or is being
// taken, whether or not it causes a result, so a result that the receiver has
// not taken holds the input back.
// expected_id (index 0, reset 1) and expected_command (index 1, reset 0) are
// written through the cfg port; the user must write them only while no frame
// is in flight, as the block itself does not enforce it.
module response_frame_checker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [rfc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rfc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // byte input
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rfc_pkg::InDataW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  logic                           s_axis_tlast,   // end_of_frame
  // results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rfc_pkg::OutDataW-1:0]   m_axis_tdata,   // [7:0] payload_byte,
                                                         // [15:8] payload_index,
                                                         // [18:16] frame_status,
                                                         // [26:19] declared_length
  output logic                           m_axis_tuser    // result_kind
);
  import rfc_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     out_ready;
  logic     take;
  logic     res_valid;
  result_t  res;

  assign s_item.rx_byte = s_axis_tdata;
  assign s_item.last    = s_axis_tlast;

  // Process the held item when the result slot is free
  assign take = item_valid && out_ready;

  rfc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_item_i  (s_item),
    .take_i    (take),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  rfc_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rfc_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take && res_valid),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

/* rtl/rfc_in_stage.sv */
// Input register stage of the response frame checker.
module rfc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  rfc_pkg::in_item_t s_item_i,
  input  logic              take_i,
  output logic              valid_o,
  output rfc_pkg::in_item_t item_o
);
  import rfc_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Accept when empty or when the held item moves on this cycle
  assign s_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  // Capture payload with the handshake
  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= s_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/rfc_check.sv */
// Frame state, configuration registers and per-byte checking logic.
module rfc_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rfc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [rfc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          take_i,
  input  rfc_pkg::in_item_t             item_i,
  output logic                          res_valid_o,
  output rfc_pkg::result_t              res_o
);
  import rfc_pkg::*;

  logic [7:0]        exp_id_q;
  logic [7:0]        exp_cmd_q;
  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        len_q, len_d;
  field_err_e        ferr_q, ferr_d;

  logic [7:0]  b;
  logic [CountW:0] n;
  logic [CountW:0] exp_size;
  logic [CountW:0] payload_end;
  logic        in_payload;
  status_e     status;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q  <= 8'd1;
      exp_cmd_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_EXPECTED_ID:  exp_id_q  <= cfg_wdata_i;
        REG_EXPECTED_CMD: exp_cmd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign b = item_i.rx_byte;

  // Latch the first header field mismatch and the length byte
  always_comb begin
    ferr_d = ferr_q;
    if (ferr_q == FE_NONE) begin
      if (count_q == CountW'(0) && b != FrameHeader) begin
        ferr_d = FE_HEADER;
      end else if (count_q == CountW'(1) && b != exp_id_q) begin
        ferr_d = FE_ID;
      end else if (count_q == CountW'(2) && b != exp_cmd_q) begin
        ferr_d = FE_COMMAND;
      end
    end
    len_d = (count_q == CountW'(3)) ? b : len_q;
  end

  assign n           = {1'b0, count_q} + (CountW+1)'(1);
  assign exp_size    = MinFrameSize + {2'b00, len_d};
  assign payload_end = (CountW+1)'(4) + {2'b00, len_d};
  assign in_payload  = (count_q >= CountW'(4)) && ({1'b0, count_q} < payload_end);

  // Final status in priority order
  always_comb begin
    if (n < MinFrameSize) begin
      status = ST_SHORT;
    end else if (ferr_d != FE_NONE) begin
      status = status_e'({1'b0, ferr_d} + 3'd1);
    end else if (n != exp_size) begin
      status = ST_SIZE;
    end else if (b != ~sum_q) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
  end

  // Result for the current item
  always_comb begin
    res_o.declared_length = len_d;
    if (item_i.last) begin
      res_valid_o         = 1'b1;
      res_o.kind          = KIND_STATUS;
      res_o.payload_byte  = 8'd0;
      res_o.payload_index = 8'd0;
      res_o.frame_status  = status;
    end else begin
      res_valid_o         = in_payload;
      res_o.kind          = KIND_PAYLOAD;
      res_o.payload_byte  = b;
      res_o.payload_index = 8'(count_q - CountW'(4));
      res_o.frame_status  = ST_OK;
    end
  end

  // Next frame state: clear after the final byte
  always_comb begin
    if (item_i.last) begin
      count_d = '0;
      sum_d   = '0;
    end else begin
      count_d = (count_q == CountMax) ? count_q : count_q + CountW'(1);
      sum_d   = sum_q + b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      len_q   <= '0;
      ferr_q  <= FE_NONE;
    end else if (take_i) begin
      count_q <= count_d;
      sum_q   <= sum_d;
      len_q   <= item_i.last ? 8'd0 : len_d;
      ferr_q  <= item_i.last ? FE_NONE : ferr_d;
    end
  end

endmodule

/* rtl/rfc_out_stage.sv */
// Output result register of the response frame checker.
module rfc_out_stage (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  rfc_pkg::result_t               res_i,
  output logic                           ready_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic                           m_axis_tuser,
  output logic [rfc_pkg::OutDataW-1:0]   m_axis_tdata
);
  import rfc_pkg::*;

  logic    valid_q;
  result_t res_q;

  // Free when empty or when the held result is taken this cycle
  assign ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  // Pack fields, lowest first
  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {5'd0, res_q.declared_length, res_q.frame_status,
                          res_q.payload_index, res_q.payload_byte};

endmodule

/* test/response_frame_checker_core_monitor.sv */
// Channel monitor for the response frame checker: predicts every result and compares.
`timescale 1ns / 100ps

module response_frame_checker_core_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rfc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rfc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [rfc_pkg::InDataW-1:0]    s_axis_tdata,   // [7:0] rx_byte
  input  logic                           s_axis_tlast,   // end_of_frame
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [rfc_pkg::OutDataW-1:0]   m_axis_tdata,   // [7:0] payload_byte,
                                                         // [15:8] payload_index,
                                                         // [18:16] frame_status,
                                                         // [26:19] declared_length
  input  logic                           m_axis_tuser,   // result_kind
  output int                             mismatch_count_o,
  output int                             pending_o
);
  import rfc_pkg::*;

  localparam logic [7:0] IdAtReset  = 8'd1;
  localparam logic [7:0] CmdAtReset = 8'd0;

  // Local copy of the registers and of the frame state
  logic [7:0]        want_id;
  logic [7:0]        want_cmd;
  logic [CountW-1:0] frame_pos;
  logic [7:0]        byte_sum;
  logic [7:0]        length_byte;
  field_err_e        first_err;

  result_t awaited_results[$];
  int      mismatches;

  task automatic clear_frame();
    frame_pos   = '0;
    byte_sum    = '0;
    length_byte = '0;
    first_err   = FE_NONE;
  endtask

  // Append one expectation behind the others
  task automatic queue_result(input result_t r);
    awaited_results = {awaited_results, r};
  endtask

  // Advance the frame state by one byte and queue the result it causes
  task automatic absorb_rx_byte(input logic [7:0] rx, input logic eof);
    int      pos;
    int      n;
    status_e st;
    result_t r;
    pos = int'(frame_pos);
    // Hold only the first field error of the frame
    if (first_err == FE_NONE) begin
      if (pos == 0 && rx != FrameHeader) first_err = FE_HEADER;
      else if (pos == 1 && rx != want_id) first_err = FE_ID;
      else if (pos == 2 && rx != want_cmd) first_err = FE_COMMAND;
    end
    if (pos == 3) length_byte = rx;

    if (eof) begin
      n = pos + 1;
      if (n < int'(MinFrameSize)) begin
        st = ST_SHORT;
      end else if (first_err != FE_NONE) begin
        case (first_err)
          FE_HEADER: st = ST_HEADER;
          FE_ID:     st = ST_ID;
          default:   st = ST_COMMAND;
        endcase
      end else if (n != int'(MinFrameSize) + int'(length_byte)) begin
        st = ST_SIZE;
      end else if (rx != ~byte_sum) begin
        st = ST_CHECKSUM;
      end else begin
        st = ST_OK;
      end
      r.kind            = KIND_STATUS;
      r.payload_byte    = '0;
      r.payload_index   = '0;
      r.frame_status    = st;
      r.declared_length = length_byte;
      queue_result(r);
      clear_frame();
    end else begin
      byte_sum = byte_sum + rx;
      if (frame_pos != CountMax) frame_pos = frame_pos + 1'b1;
      // Pass payload bytes through with their index
      if (pos >= 4 && pos < 4 + int'(length_byte)) begin
        r.kind            = KIND_PAYLOAD;
        r.payload_byte    = rx;
        r.payload_index   = 8'(pos - 4);
        r.frame_status    = ST_OK;
        r.declared_length = length_byte;
        queue_result(r);
      end
    end
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic match_result(input logic [OutDataW-1:0] data, input logic kind);
    result_t               want;
    logic [OutDataW-1:0]   want_data;
    if (awaited_results.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: result with nothing awaited: kind=%0d data=%08h", $realtime, kind, data);
      mismatches++;
    end else begin
      want      = awaited_results.pop_front();
      want_data = '0;
      want_data[7:0]   = want.payload_byte;
      want_data[15:8]  = want.payload_index;
      want_data[18:16] = want.frame_status;
      want_data[26:19] = want.declared_length;
      if (kind !== want.kind || data !== want_data) begin
        if (mismatches < 10)
          $display({"%0t: result mismatch: expected kind=%0d byte=%02h index=%0d status=%0d ",
                    "length=%0d pad=00, got kind=%0d byte=%02h index=%0d status=%0d ",
                    "length=%0d pad=%02h"},
                   $realtime, want.kind, want.payload_byte, want.payload_index,
                   want.frame_status, want.declared_length, kind, data[7:0], data[15:8],
                   data[18:16], data[26:19], data[OutDataW-1:27]);
        mismatches++;
      end
    end
  endtask

  // Watch all three ports at every rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_id  = IdAtReset;
      want_cmd = CmdAtReset;
      clear_frame();
      awaited_results.delete();
      mismatches = 0;
      pending_o        <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) match_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) absorb_rx_byte(s_axis_tdata, s_axis_tlast);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_EXPECTED_ID:  want_id  = cfg_wdata_i;
          REG_EXPECTED_CMD: want_cmd = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o        <= awaited_results.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

/* test/response_frame_checker_core_test.sv */
// Stimulus and verdict for the response frame checker, with the monitor beside the block.
`timescale 1ns / 100ps

module response_frame_checker_core_test;
  import rfc_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int SettleCount = 4;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  cfg_idx_e             cfg_idx_i     = REG_EXPECTED_ID;
  logic [CfgDataW-1:0]  cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  int                   mismatch_count;
  int                   pending;

  int         cycle_count = 0;
  int         stall_left  = 0;
  logic       stalls_on   = 1'b0;
  logic       gaps_on     = 1'b0;
  logic [7:0] cur_id      = 8'd1;
  logic [7:0] cur_cmd     = 8'd0;
  logic [7:0] frame_buf[$];
  int         bytes_sent  = 0;

  response_frame_checker_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  response_frame_checker_core_monitor monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: stall in random bursts when stalls are on
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Append one byte to the frame under construction
  task automatic append_byte(input logic [7:0] val);
    frame_buf = {frame_buf, val};
  endtask

  // Offer one item and hold it until accepted
  task automatic send_item(input logic [7:0] rx, input logic eof);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    s_axis_tlast  <= eof;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_item(frame_buf[i], i == frame_buf.size() - 1);
    frame_buf.delete();
  endtask

  // Append the inverted byte sum, optionally corrupted
  task automatic add_checksum(input logic corrupt);
    logic [7:0] acc;
    acc = '0;
    foreach (frame_buf[i]) acc = acc + frame_buf[i];
    acc = ~acc;
    if (corrupt) acc = acc ^ 8'($urandom_range(1, 255));
    append_byte(acc);
  endtask

  // Stop sending and hold until every result is out and the pipeline is empty
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCount) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] id, input logic [7:0] cmd);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_EXPECTED_ID;
    cfg_wdata_i <= id;
    @(posedge clk_i);
    cfg_idx_i   <= REG_EXPECTED_CMD;
    cfg_wdata_i <= cmd;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_id  = id;
    cur_cmd = cmd;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] val);
    return val ^ 8'($urandom_range(1, 255));
  endfunction

  // Build one frame: mostly well formed, the rest broken or noise
  task automatic random_frame();
    int         pick;
    int         len;
    int         npay;
    logic [7:0] hdr;
    logic [7:0] id;
    logic [7:0] cmd;
    pick = $urandom_range(0, 99);
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    if (pick >= 86 && pick < 93) begin
      // too short, sometimes with a proper start
      npay = $urandom_range(1, 4);
      for (int i = 0; i < npay; i++) begin
        if (i == 0 && $urandom_range(0, 1) == 1) append_byte(FrameHeader);
        else if (i == 1 && $urandom_range(0, 1) == 1) append_byte(cur_id);
        else append_byte(8'($urandom_range(0, 255)));
      end
    end else if (pick >= 93) begin
      npay = $urandom_range(1, 12);
      for (int i = 0; i < npay; i++) append_byte(8'($urandom_range(0, 255)));
    end else begin
      hdr  = FrameHeader;
      id   = cur_id;
      cmd  = cur_cmd;
      npay = len;
      if (pick >= 62 && pick < 68) begin
        hdr = other_than(FrameHeader);
        if ($urandom_range(0, 1) == 1) id = other_than(cur_id);
        if ($urandom_range(0, 1) == 1) cmd = other_than(cur_cmd);
      end else if (pick >= 68 && pick < 74) begin
        id = other_than(cur_id);
        if ($urandom_range(0, 1) == 1) cmd = other_than(cur_cmd);
      end else if (pick >= 74 && pick < 80) begin
        cmd = other_than(cur_cmd);
      end else if (pick >= 80 && pick < 86) begin
        // payload cut short or running past its length
        if (len > 0 && $urandom_range(0, 1) == 1) npay = $urandom_range(0, len - 1);
        else npay = len + $urandom_range(1, 4);
      end
      append_byte(hdr);
      append_byte(id);
      append_byte(cmd);
      append_byte(8'(len));
      for (int i = 0; i < npay; i++) append_byte(8'($urandom_range(0, 255)));
      add_checksum(pick >= 55 && pick < 62);
    end
    send_frame();
  endtask

  // Well-formed header followed by a given payload length and byte count
  task automatic long_frame(input logic [7:0] len, input int npay);
    append_byte(FrameHeader);
    append_byte(cur_id);
    append_byte(cur_cmd);
    append_byte(len);
    for (int i = 0; i < npay; i++) append_byte(8'($urandom_range(0, 255)));
    add_checksum(1'b0);
    send_frame();
  endtask

  initial begin
    int         phase_start;
    logic [7:0] new_id;
    logic [7:0] new_cmd;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset register values
    frame_buf = '{FrameHeader, 8'h01, 8'h00, 8'h00};
    add_checksum(1'b0);
    send_frame();
    frame_buf = '{8'h00};
    send_frame();
    // ends on the length byte
    frame_buf = '{FrameHeader, 8'h01, 8'h00, 8'hFF};
    send_frame();
    // header error outranks id and command errors
    frame_buf = '{8'h55, 8'h02, 8'h03, 8'h00};
    add_checksum(1'b0);
    send_frame();
    frame_buf = '{FrameHeader, 8'h02, 8'hFF, 8'h00};
    add_checksum(1'b0);
    send_frame();
    frame_buf = '{FrameHeader, 8'h01, 8'h07, 8'h00};
    add_checksum(1'b0);
    send_frame();
    frame_buf = '{FrameHeader, 8'h01, 8'h00, 8'h02, 8'hFF, 8'h00};
    add_checksum(1'b0);
    send_frame();
    frame_buf = '{FrameHeader, 8'h01, 8'h00, 8'h01, 8'h5A};
    add_checksum(1'b1);
    send_frame();
    // end of frame inside the payload
    frame_buf = '{FrameHeader, 8'h01, 8'h00, 8'h03, 8'h11, 8'h22};
    send_frame();
    // bytes past the payload before the checksum
    frame_buf = '{FrameHeader, 8'h01, 8'h00, 8'h01, 8'h33, 8'h44, 8'h55};
    add_checksum(1'b0);
    send_frame();

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin new_id = 8'h00; new_cmd = 8'h00; end
        1: begin new_id = 8'hFF; new_cmd = 8'hFF; end
        3: begin new_id = FrameHeader; new_cmd = 8'h55; end
        default: begin
          new_id  = 8'($urandom_range(0, 255));
          new_cmd = 8'($urandom_range(0, 255));
        end
      endcase
      set_config(new_id, new_cmd);
      case (phase)
        0, 4: begin gaps_on = 1'b1; stalls_on <= 1'b1; end
        1:    begin gaps_on = 1'b1; stalls_on <= 1'b0; end
        2:    begin gaps_on = 1'b0; stalls_on <= 1'b1; end
        3:    begin gaps_on = 1'($urandom_range(0, 1)); stalls_on <= 1'($urandom_range(0, 1)); end
        default: begin gaps_on = 1'b0; stalls_on <= 1'b0; end
      endcase
      // largest declared length with a byte count that saturates
      if (phase == 2) long_frame(8'hFF, 525);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 40) random_frame();
    end

    drain();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
